// File: sv/ipu_pkg.sv
package ipu_pkg;

   // Image size registers saturate here.
   localparam logic [12:0] DIM_MAX = 13'd4096;
   // Largest canvas size, in pixels.
   localparam logic [24:0] ADDR_SPACE = 25'h100_0000;
   localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

   // Request kinds, carried on req_tuser.
   localparam logic [1:0] OP_PALETTE = 2'd0;
   localparam logic [1:0] OP_DATA = 2'd1;
   localparam logic [1:0] OP_START = 2'd2;

   // Register indexes on the csr port.
   localparam logic [2:0] CSR_FOUR_BIT_MODE = 3'd0;
   localparam logic [2:0] CSR_IMAGE_WIDTH = 3'd1;
   localparam logic [2:0] CSR_IMAGE_HEIGHT = 3'd2;
   localparam logic [2:0] CSR_CANVAS_PITCH = 3'd3;
   localparam logic [2:0] CSR_DEST_X = 3'd4;
   localparam logic [2:0] CSR_DEST_Y = 3'd5;
   localparam logic [2:0] CSR_FLIP_VERTICAL = 3'd6;
   localparam logic [2:0] CSR_CANVAS_LIMIT = 3'd7;

   typedef struct packed {
      logic        four_bit_mode;
      logic [12:0] image_width;
      logic [12:0] image_height;
      logic [12:0] canvas_pitch;
      logic [11:0] dest_x;
      logic [11:0] dest_y;
      logic        flip_vertical;
      logic [24:0] canvas_limit_pixels;
   } cfg_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [3:0] palette_slot;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
      logic [7:0] data_byte;
   } req_type;

   // One unit of work for the pixel emitter: a palette write or up to four pixels.
   typedef struct packed {
      logic            is_palette;
      logic [23:0]     base;
      logic [3:0]      mask;
      logic [3:0][3:0] idx;
      logic [3:0]      slot;
      logic [23:0]     rgb;
   } job_type;

   typedef struct packed {
      logic [23:0] write_address;
      logic [7:0]  red_out;
      logic [7:0]  green_out;
      logic [7:0]  blue_out;
      logic        last_of_byte;
   } rsp_type;

endpackage

// File: sv/indexed_pixel_unpack_to_rgba.sv
// Indexed pixel unpacker: 2/4-bit palette PNG scanline bytes in, RGBA canvas
// writes out.
//
// req channel: one request per edge with req_tvalid & req_tready. req_tuser
// is the request kind (palette entry write, scanline byte, start of image).
// rsp channel: one canvas pixel write per beat, rsp_tlast on the last write
// caused by a scanline byte. Bytes with no opaque pixel produce no beat.
// csr port: csr_we writes csr_wdata into register csr_index;
// only write while nothing is in flight.
//
// A byte's first write passes the input register, the emitter's job register
// and the output register on its way to rsp. The block takes one request per
// cycle while the emitter and rsp keep up; a scanline byte holds the pixel
// emitter until it has sent every opaque pixel it produces, up to four in
// 2-bit mode and two in 4-bit mode. rsp carries one pixel write per beat.
//
// Reset clears the palette to black, the row/byte position, the finished
// flag and loads the register defaults. If rsp_tready is low, the output
// register holds its write, the emitter and then the input register fill,
// and req_tready drops; nothing is lost.
module indexed_pixel_unpack_to_rgba #(
   parameter int PALETTE_ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // palette_slot, red_in, green_in, blue_in, data_byte, pad
   input  logic [1:0]  req_tuser,   // opcode
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // write_address, red_out, green_out, blue_out, alpha_out
   output logic        rsp_tlast,   // last_of_byte
   // register writes
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [24:0] csr_wdata
);
   import ipu_pkg::*;

   cfg_type cfg_ff;
   req_type in_ff, in_in;
   logic    in_valid_ff;
   logic    take;
   logic    job_valid, job_ready;
   job_type job;
   rsp_type rsp;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.four_bit_mode <= 1'b1;
         cfg_ff.image_width <= 13'd1;
         cfg_ff.image_height <= 13'd1;
         cfg_ff.canvas_pitch <= 13'd1;
         cfg_ff.dest_x <= 12'd0;
         cfg_ff.dest_y <= 12'd0;
         cfg_ff.flip_vertical <= 1'b0;
         cfg_ff.canvas_limit_pixels <= 25'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FOUR_BIT_MODE: cfg_ff.four_bit_mode <= csr_wdata[0];
            CSR_IMAGE_WIDTH:   cfg_ff.image_width <= csr_wdata[12:0];
            CSR_IMAGE_HEIGHT:  cfg_ff.image_height <= csr_wdata[12:0];
            CSR_CANVAS_PITCH:  cfg_ff.canvas_pitch <= csr_wdata[12:0];
            CSR_DEST_X:        cfg_ff.dest_x <= csr_wdata[11:0];
            CSR_DEST_Y:        cfg_ff.dest_y <= csr_wdata[11:0];
            CSR_FLIP_VERTICAL: cfg_ff.flip_vertical <= csr_wdata[0];
            CSR_CANVAS_LIMIT:  cfg_ff.canvas_limit_pixels <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input register: takes a new request when empty or when the held one moves on.
   always_comb begin
      in_in.opcode = req_tuser;
      in_in.palette_slot = req_tdata[3:0];
      in_in.red_in = req_tdata[11:4];
      in_in.green_in = req_tdata[19:12];
      in_in.blue_in = req_tdata[27:20];
      in_in.data_byte = req_tdata[35:28];
      req_tready = !in_valid_ff || take;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_ff <= in_in;
      end
   end

   // Row tracking, limit check and index split.
   ipu_decode #(
      .PALETTE_ENTRIES(PALETTE_ENTRIES)
   ) u_decode (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_valid (in_valid_ff),
      .in_req   (in_ff),
      .take     (take),
      .job_valid(job_valid),
      .job      (job),
      .job_ready(job_ready)
   );

   // Palette and one-pixel-per-cycle output while rsp_tready is high.
   ipu_emit #(
      .PALETTE_ENTRIES(PALETTE_ENTRIES)
   ) u_emit (
      .clock    (clock),
      .reset    (reset),
      .job_valid(job_valid),
      .job      (job),
      .job_ready(job_ready),
      .rsp_valid(rsp_tvalid),
      .rsp      (rsp),
      .rsp_ready(rsp_tready)
   );

   assign rsp_tdata = {ALPHA_OPAQUE, rsp.blue_out, rsp.green_out, rsp.red_out,
                       rsp.write_address};
   assign rsp_tlast = rsp.last_of_byte;

endmodule

// File: sv/ipu_decode.sv
module ipu_decode #(
   parameter int PALETTE_ENTRIES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  ipu_pkg::cfg_type cfg,
   input  logic             in_valid,
   input  ipu_pkg::req_type in_req,
   output logic             take,
   output logic             job_valid,
   output ipu_pkg::job_type job,
   input  logic             job_ready
);
   import ipu_pkg::*;

   logic [11:0] byte_in_row_ff, byte_in_row_in;
   logic [12:0] row_count_ff, row_count_in;
   logic        image_finished_ff, image_finished_in;
   logic [25:0] row_prod_ff;

   logic [12:0] width_sat, height_sat;
   logic [13:0] stride_wide;
   logic [11:0] stride;
   logic [13:0] y_wide;
   logic [25:0] row_prod_in;
   logic [10:0] b_m1;
   logic [12:0] first_x, remain;
   logic [2:0]  ppb, count;
   logic [26:0] base, last_addr;
   logic [24:0] limit_sat;
   logic        in_pixels, overrun;
   logic [12:0] b_next;
   logic [12:0] row_next;
   logic [3:0][3:0] idx;
   logic [3:0]  mask;
   logic [7:0]  d;

   // Row product is recomputed every cycle from the live row counter. It is
   // registered, so it lags behind a row change, but the byte that follows a row
   // change is always a filter byte, which needs no address.
   always_comb begin
      if (cfg.flip_vertical) begin
         y_wide = 14'(cfg.dest_y) + 14'(height_sat) - 14'd1 - 14'(row_count_ff);
      end else begin
         y_wide = 14'(cfg.dest_y) + 14'(row_count_ff);
      end
      row_prod_in = y_wide[12:0] * cfg.canvas_pitch;
   end

   always_ff @(posedge clock) begin
      row_prod_ff <= row_prod_in;
   end

   always_comb begin
      width_sat = (cfg.image_width > DIM_MAX) ? DIM_MAX : cfg.image_width;
      height_sat = (cfg.image_height > DIM_MAX) ? DIM_MAX : cfg.image_height;
      limit_sat = (cfg.canvas_limit_pixels > ADDR_SPACE) ? ADDR_SPACE
                                                        : cfg.canvas_limit_pixels;
      // stride = 1 + ceil(width * depth / 8)
      if (cfg.four_bit_mode) begin
         stride_wide = 14'd1 + ((14'(width_sat) + 14'd1) >> 1);
         ppb = 3'd2;
      end else begin
         stride_wide = 14'd1 + ((14'(width_sat) + 14'd3) >> 2);
         ppb = 3'd4;
      end
      stride = stride_wide[11:0];

      in_pixels = (byte_in_row_ff != 12'd0) && (byte_in_row_ff < stride);
      b_m1 = 11'(byte_in_row_ff - 12'd1);
      first_x = cfg.four_bit_mode ? {1'b0, b_m1, 1'b0} : {b_m1, 2'b00};
      remain = width_sat - first_x;
      count = (remain < 13'(ppb)) ? remain[2:0] : ppb;

      base = 27'(row_prod_ff) + 27'(cfg.dest_x) + 27'(first_x);
      last_addr = base + 27'(count) - 27'd1;
      overrun = last_addr >= 27'(limit_sat);

      // Split the byte into indices, most significant bits first.
      d = in_req.data_byte;
      if (cfg.four_bit_mode) begin
         idx[0] = d[7:4];
         idx[1] = d[3:0];
         idx[2] = 4'd0;
         idx[3] = 4'd0;
      end else begin
         idx[0] = {2'b00, d[7:6]};
         idx[1] = {2'b00, d[5:4]};
         idx[2] = {2'b00, d[3:2]};
         idx[3] = {2'b00, d[1:0]};
      end
      for (int k = 0; k < 4; k++) begin
         mask[k] = (3'(k) < count) && (idx[k] != 4'd0) &&
                   ({1'b0, idx[k]} < 5'(PALETTE_ENTRIES));
      end

      b_next = 13'(byte_in_row_ff) + 13'd1;
      row_next = row_count_ff + 13'd1;

      byte_in_row_in = byte_in_row_ff;
      row_count_in = row_count_ff;
      image_finished_in = image_finished_ff;

      job_valid = 1'b0;
      job.is_palette = 1'b0;
      job.base = base[23:0];
      job.mask = mask;
      job.idx = idx;
      job.slot = in_req.palette_slot;
      job.rgb = {in_req.red_in, in_req.green_in, in_req.blue_in};

      if (in_valid) begin
         if (in_req.opcode == OP_PALETTE) begin
            job_valid = {1'b0, in_req.palette_slot} < 5'(PALETTE_ENTRIES);
            job.is_palette = 1'b1;
         end else if (in_req.opcode == OP_START) begin
            byte_in_row_in = 12'd0;
            row_count_in = 13'd0;
            image_finished_in = 1'b0;
         end else if (in_req.opcode == OP_DATA && !image_finished_ff) begin
            if (row_count_ff >= height_sat) begin
               image_finished_in = 1'b1;
            end else if (in_pixels && overrun) begin
               image_finished_in = 1'b1;
            end else begin
               job_valid = in_pixels && (mask != 4'd0);
               if (b_next >= 13'(stride)) begin
                  byte_in_row_in = 12'd0;
                  row_count_in = row_next;
                  if (row_next >= height_sat) begin
                     image_finished_in = 1'b1;
                  end
               end else begin
                  byte_in_row_in = b_next[11:0];
               end
            end
         end
      end

      take = in_valid && (!job_valid || job_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_in_row_ff <= 12'd0;
         row_count_ff <= 13'd0;
         image_finished_ff <= 1'b0;
      end else if (take) begin
         byte_in_row_ff <= byte_in_row_in;
         row_count_ff <= row_count_in;
         image_finished_ff <= image_finished_in;
      end
   end

endmodule

// File: sv/ipu_emit.sv
module ipu_emit #(
   parameter int PALETTE_ENTRIES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  ipu_pkg::job_type job,
   output logic             job_ready,
   output logic             rsp_valid,
   output ipu_pkg::rsp_type rsp,
   input  logic             rsp_ready
);
   import ipu_pkg::*;

   localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

   job_type     job_ff;
   logic        job_valid_ff;
   logic [3:0]  mask_ff;
   logic [23:0] palette_ff [PALETTE_ENTRIES];
   logic        rsp_valid_ff;
   rsp_type     rsp_ff, rsp_in;

   logic [1:0]  pick_k;
   logic [3:0]  pick_bits;
   logic [3:0]  mask_left;
   logic [3:0]  idx_sel;
   logic [23:0] rgb_sel;
   logic        out_free, load, last, done;

   always_comb begin
      // Lowest remaining opaque pixel goes next.
      pick_k = 2'd0;
      for (int k = 3; k >= 0; k--) begin
         if (mask_ff[k]) begin
            pick_k = 2'(k);
         end
      end
      pick_bits = mask_ff & ~(mask_ff - 4'd1);
      mask_left = mask_ff & ~pick_bits;
      last = (mask_left == 4'd0);

      idx_sel = job_ff.idx[pick_k];
      rgb_sel = palette_ff[idx_sel[IDX_W-1:0]];

      out_free = !rsp_valid_ff || rsp_ready;
      load = job_valid_ff && !job_ff.is_palette && out_free;
      done = job_valid_ff && (job_ff.is_palette || (load && last));
      job_ready = !job_valid_ff || done;

      rsp_in.write_address = job_ff.base + 24'(pick_k);
      rsp_in.red_out = rgb_sel[23:16];
      rsp_in.green_out = rgb_sel[15:8];
      rsp_in.blue_out = rgb_sel[7:0];
      rsp_in.last_of_byte = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < PALETTE_ENTRIES; i++) begin
            palette_ff[i] <= 24'd0;
         end
      end else begin
         if (job_valid_ff && job_ff.is_palette) begin
            palette_ff[job_ff.slot[IDX_W-1:0]] <= job_ff.rgb;
         end
         if (job_ready) begin
            job_valid_ff <= job_valid;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_ready) begin
         job_ff <= job;
         mask_ff <= job.mask;
      end else if (load) begin
         mask_ff <= mask_left;
      end
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

   a_pixel_job_has_work: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff && !job_ff.is_palette |-> mask_ff != 4'd0)
      else $error("pixel job held with no opaque pixel left");

   a_pick_onehot: assert property (@(posedge clock) disable iff (reset)
      mask_ff != 4'd0 |-> $onehot(pick_bits) && pick_bits[pick_k])
      else $error("pixel pick is not a single remaining bit");

   a_load_fills_output: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid_ff)
      else $error("loaded pixel did not reach the output register");

   a_job_stays_until_done: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff && !done |=> job_valid_ff)
      else $error("unfinished job dropped");

endmodule

// File: bench/indexed_pixel_unpack_to_rgba_tb.sv
`timescale 1ns / 1ps

module indexed_pixel_unpack_to_rgba_tb;
   import ipu_pkg::*;

   localparam int PAL_ENTRIES    = 16;
   localparam int DRAIN_CYCLES   = 20;     // pipeline registers plus a byte holding the emitter for up to 4 pixels
   localparam int HOLD_CYCLES    = 400;    // long receiver hold-off
   localparam int WATCHDOG_LIMIT = 3000;   // cycles without any handshake
   // The package names only the three live request kinds.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;    // palette_slot, red_in, green_in, blue_in, data_byte, pad
   logic [1:0]  req_tuser;    // opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;    // write_address, red_out, green_out, blue_out, alpha_out
   logic        rsp_tlast;    // last_of_byte
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [24:0] csr_wdata;

   indexed_pixel_unpack_to_rgba dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow of the block: register mirror, palette and scan position.
   // ---------------------------------------------------------------------
   cfg_type     regs;
   logic [23:0] palette [PAL_ENTRIES];
   logic [11:0] byte_pos;       // byte index within the current row, 0 = filter byte
   logic [12:0] row_pos;
   logic        image_done;
   rsp_type     pixel_writes_due [$];

   int errors = 0;
   int reqs_sent;
   int writes_checked = 0;
   int images_started;

   // Idle knobs: percent of cycles the sender idles / the receiver stalls.
   int   send_idle_pct;
   int   recv_stall_pct;
   logic hold_toggle = 1'b0;    // flips to ask the receiver for a long hold-off
   logic hold_seen = 1'b0;
   int   hold_left = 0;
   int   quiet_cycles = 0;

   function automatic int unsigned sat_dim(input logic [12:0] v);
      return 32'((v > DIM_MAX) ? DIM_MAX : v);
   endfunction

   // Bytes per row: filter byte plus the packed pixels.
   function automatic int unsigned row_bytes();
      int unsigned depth;
      depth = regs.four_bit_mode ? 4 : 2;
      return 1 + (sat_dim(regs.image_width) * depth + 7) / 8;
   endfunction

   // Works out the canvas writes one accepted request causes, in order.
   function automatic void predict_pixels(input req_type r);
      int unsigned wid, hgt, depth, ppb, stride, b, first_x, cnt, y, lim, idx, n;
      longint unsigned base;
      rsp_type px;
      case (r.opcode)
         OP_PALETTE: begin
            if (r.palette_slot < PAL_ENTRIES)
               palette[r.palette_slot] = {r.red_in, r.green_in, r.blue_in};
         end
         OP_START: begin
            byte_pos   = '0;
            row_pos    = '0;
            image_done = 1'b0;
            images_started++;
         end
         OP_DATA: begin
            if (image_done)
               return;
            wid = sat_dim(regs.image_width);
            hgt = sat_dim(regs.image_height);
            if (row_pos >= hgt) begin
               image_done = 1'b1;
               return;
            end
            depth  = regs.four_bit_mode ? 4 : 2;
            ppb    = 8 / depth;
            stride = row_bytes();
            b      = 32'(byte_pos);
            n      = 0;
            // byte 0 is the filter byte; a position past the stride (after a
            // width change) only wraps the row
            if (b != 0 && b < stride) begin
               first_x = (b - 1) * ppb;
               cnt     = ppb;
               if (first_x + cnt > wid)
                  cnt = wid - first_x;
               y = regs.flip_vertical ? regs.dest_y + hgt - 1 - row_pos
                                      : regs.dest_y + row_pos;
               base = y;
               base = base * regs.canvas_pitch + regs.dest_x + first_x;
               lim  = 32'((regs.canvas_limit_pixels > ADDR_SPACE) ? ADDR_SPACE
                                                                 : regs.canvas_limit_pixels);
               // overrun test uses the last in-width pixel, opaque or not
               if (base + cnt - 1 >= lim) begin
                  image_done = 1'b1;
                  return;
               end
               for (int k = 0; k < cnt; k++) begin
                  idx = (32'(r.data_byte) >> (8 - depth * (k + 1))) & ((1 << depth) - 1);
                  if (idx != 0 && idx < PAL_ENTRIES) begin
                     px.write_address = 24'(base + k);
                     px.red_out       = palette[idx][23:16];
                     px.green_out     = palette[idx][15:8];
                     px.blue_out      = palette[idx][7:0];
                     px.last_of_byte  = 1'b0;
                     pixel_writes_due.push_back(px);
                     n++;
                  end
               end
               if (n > 0)
                  pixel_writes_due[pixel_writes_due.size() - 1].last_of_byte = 1'b1;
            end
            if (b + 1 >= stride) begin
               byte_pos = '0;
               row_pos  = row_pos + 13'd1;
               if (row_pos >= hgt)
                  image_done = 1'b1;
            end else begin
               byte_pos = 12'(b + 1);
            end
         end
         default: ;   // unused opcode: nothing happens
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Driving side
   // ---------------------------------------------------------------------

   // Request of a given kind with every field random; unused fields stay random.
   function automatic req_type op_req(input logic [1:0] opcode);
      req_type r;
      r.opcode       = opcode;
      r.palette_slot = 4'($urandom_range(15));
      r.red_in       = 8'($urandom_range(255));
      r.green_in     = 8'($urandom_range(255));
      r.blue_in      = 8'($urandom_range(255));
      r.data_byte    = 8'($urandom_range(255));
      return r;
   endfunction

   function automatic req_type data_req(input logic [7:0] value);
      req_type r;
      r = op_req(OP_DATA);
      r.data_byte = value;
      return r;
   endfunction

   function automatic req_type palette_req(input logic [3:0] slot,
                                           input logic [23:0] rgb);
      req_type r;
      r = op_req(OP_PALETTE);
      r.palette_slot = slot;
      {r.red_in, r.green_in, r.blue_in} = rgb;
      return r;
   endfunction

   function automatic cfg_type make_cfg(input logic four, input logic [12:0] w,
                                        input logic [12:0] h, input logic [12:0] cw,
                                        input logic [11:0] dx, input logic [11:0] dy,
                                        input logic flip, input logic [24:0] lim);
      cfg_type c;
      c.four_bit_mode       = four;
      c.image_width         = w;
      c.image_height        = h;
      c.canvas_pitch        = cw;
      c.dest_x              = dx;
      c.dest_y              = dy;
      c.flip_vertical       = flip;
      c.canvas_limit_pixels = lim;
      return c;
   endfunction

   // Offer one request, wait for the handshake, then update the shadow.
   // tvalid stays high across back-to-back requests.
   task automatic send_req(input req_type r);
      logic taken;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.opcode;
      req_tdata  <= {4'h0, r.data_byte, r.blue_in, r.green_in, r.red_in, r.palette_slot};
      // tready sampled mid-cycle, where it is stable, decides the next edge
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
      predict_pixels(r);
      reqs_sent++;
   endtask

   // Stop offering, wait for every due write, then let trailing
   // no-write requests leave the pipeline.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pixel_writes_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // All eight registers, one per cycle; call only when idle.
   task automatic write_registers(input cfg_type c);
      logic [2:0]  reg_index [8];
      logic [24:0] reg_value [8];
      reg_index = '{CSR_FOUR_BIT_MODE, CSR_IMAGE_WIDTH, CSR_IMAGE_HEIGHT,
                    CSR_CANVAS_PITCH, CSR_DEST_X, CSR_DEST_Y, CSR_FLIP_VERTICAL,
                    CSR_CANVAS_LIMIT};
      reg_value = '{25'(c.four_bit_mode), 25'(c.image_width), 25'(c.image_height),
                    25'(c.canvas_pitch), 25'(c.dest_x), 25'(c.dest_y),
                    25'(c.flip_vertical), c.canvas_limit_pixels};
      for (int i = 0; i < 8; i++) begin
         csr_we    <= 1'b1;
         csr_index <= reg_index[i];
         csr_wdata <= reg_value[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      regs = c;
   endtask

   // Random geometry, mostly small, with the register extremes mixed in.
   function automatic cfg_type choose_geometry();
      cfg_type c;
      c.four_bit_mode = 1'($urandom_range(1));
      case ($urandom_range(11))
         0:       c.image_width = 13'd0;
         1:       c.image_width = 13'h1fff;   // saturates
         2:       c.image_width = DIM_MAX;
         default: c.image_width = 13'($urandom_range(1, 20));
      endcase
      case ($urandom_range(11))
         0:       c.image_height = 13'd0;
         1:       c.image_height = 13'h1fff;
         default: c.image_height = 13'($urandom_range(1, 4));
      endcase
      case ($urandom_range(9))
         0:       c.canvas_pitch = 13'h1fff;
         1:       c.canvas_pitch = 13'd0;
         2:       c.canvas_pitch = DIM_MAX;
         default: c.canvas_pitch = 13'($urandom_range(1, 48));
      endcase
      c.dest_x = ($urandom_range(7) == 0) ? 12'hfff : 12'($urandom_range(15));
      c.dest_y = ($urandom_range(7) == 0) ? 12'hfff : 12'($urandom_range(15));
      c.flip_vertical = 1'($urandom_range(1));
      case ($urandom_range(9))
         0:       c.canvas_limit_pixels = 25'h1ffffff;   // saturates
         1:       c.canvas_limit_pixels = ADDR_SPACE;
         2:       c.canvas_limit_pixels = 25'($urandom_range(300));
         3:       c.canvas_limit_pixels = 25'd0;
         default: c.canvas_limit_pixels = 25'($urandom_range(25'h1ffffff, 20000));
      endcase
      return c;
   endfunction

   // One image: new geometry, a few palette loads, a start, then about a full
   // image of bytes, at most 36, with the odd palette load, unused opcode or restart.
   task automatic random_image();
      int n_bytes;
      settle();
      write_registers(choose_geometry());
      repeat ($urandom_range(3)) send_req(op_req(OP_PALETTE));
      send_req(op_req(OP_START));
      n_bytes = int'(row_bytes() * sat_dim(regs.image_height) + $urandom_range(2));
      if (n_bytes > 36)
         n_bytes = int'($urandom_range(20, 36));
      repeat (n_bytes) begin
         case ($urandom_range(24))
            0:       send_req(op_req(OP_PALETTE));
            1:       send_req(op_req(OP_UNUSED));
            2:       send_req(op_req(OP_START));
            default: send_req(op_req(OP_DATA));
         endcase
      end
   endtask

   // ---------------------------------------------------------------------
   // Receiving side
   // ---------------------------------------------------------------------

   // Random stalls; a hold_toggle flip parks tready low, counting down from HOLD_CYCLES.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (hold_toggle != hold_seen) begin
         hold_left = HOLD_CYCLES;
         hold_seen  <= hold_toggle;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic void check_field(input string name, input logic [23:0] want,
                                       input logic [23:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
         errors++;
      end
   endfunction

   // A beat seen with tvalid & tready mid-cycle completes at the next edge.
   always @(negedge clock) begin
      rsp_type due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pixel_writes_due.size() == 0) begin
            $display("%0t: pixel write with none pending, expected nothing, got addr %h",
                     $time, rsp_tdata[23:0]);
            errors++;
         end else begin
            due = pixel_writes_due.pop_front();
            check_field("write_address", due.write_address, rsp_tdata[23:0]);
            check_field("red_out", 24'(due.red_out), 24'(rsp_tdata[31:24]));
            check_field("green_out", 24'(due.green_out), 24'(rsp_tdata[39:32]));
            check_field("blue_out", 24'(due.blue_out), 24'(rsp_tdata[47:40]));
            check_field("alpha_out", 24'(ALPHA_OPAQUE), 24'(rsp_tdata[55:48]));
            check_field("last_of_byte", 24'(due.last_of_byte), 24'(rsp_tlast));
            writes_checked++;
         end
      end
   end

   // Watchdog: any handshake on either side restarts the count.
   always @(negedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no handshake for %0d cycles, %0d writes pending",
                     $time, quiet_cycles, pixel_writes_due.size());
            $display("FAILURE");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // 2-bit rows: all four indices in one byte, a partial last byte,
   // extreme colors, a byte after the image is done, the unused opcode.
   task automatic test_two_bit_rows();
      settle();
      write_registers(make_cfg(1'b0, 13'd5, 13'd1, 13'd16, 12'd3, 12'd1, 1'b0, ADDR_SPACE));
      send_req(palette_req(4'd1, 24'hff0000));
      send_req(palette_req(4'd2, 24'h00ff00));
      send_req(palette_req(4'd3, 24'h0000ff));
      send_req(op_req(OP_START));
      send_req(data_req(8'hff));      // filter byte
      send_req(data_req(8'he4));      // indices 3,2,1,0
      send_req(data_req(8'h7f));      // only x=4 is inside the width
      send_req(data_req(8'hff));      // image done: ignored
      send_req(op_req(OP_UNUSED));
   endtask

   // 4-bit, flipped rows, top index, far corner of a wide canvas.
   task automatic test_flip_four_bit();
      settle();
      write_registers(make_cfg(1'b1, 13'd3, 13'd2, DIM_MAX, 12'hfff, 12'd4000, 1'b1,
                               25'h1ffffff));
      send_req(palette_req(4'd15, 24'hffffff));
      send_req(palette_req(4'd8, 24'h123456));
      send_req(op_req(OP_START));
      send_req(data_req(8'h00));
      send_req(data_req(8'hf8));
      send_req(data_req(8'h80));
      send_req(data_req(8'h0f));      // filter byte of row 1
      send_req(data_req(8'h0f));
   endtask

   // Limit hit on a byte whose last in-width pixel is transparent.
   task automatic test_canvas_overrun();
      settle();
      write_registers(make_cfg(1'b0, 13'd8, 13'd2, 13'd10, 12'd0, 12'd0, 1'b0, 25'd13));
      send_req(op_req(OP_START));
      send_req(data_req(8'h00));
      send_req(data_req(8'hff));
      send_req(data_req(8'hff));
      send_req(data_req(8'h00));
      send_req(data_req(8'h40));      // addr 10..13 reaches the limit
      send_req(data_req(8'hff));      // image stopped: ignored
   endtask

   // Width shrinks mid-row: the old byte position lies past the new stride.
   task automatic test_stride_change();
      settle();
      write_registers(make_cfg(1'b0, 13'd16, 13'd3, 13'd20, 12'd0, 12'd0, 1'b0, ADDR_SPACE));
      send_req(op_req(OP_START));
      send_req(data_req(8'h00));
      send_req(data_req(8'h1b));
      settle();
      write_registers(make_cfg(1'b0, 13'd4, 13'd3, 13'd20, 12'd0, 12'd0, 1'b0, ADDR_SPACE));
      send_req(data_req(8'hff));      // wraps the row, no writes
      send_req(data_req(8'h00));
      send_req(data_req(8'he4));
   endtask

   // Receiver parks for a long stretch while a dense image keeps coming,
   // so the block backs up into req_tready; then drain completely.
   task automatic test_backpressure();
      settle();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_registers(make_cfg(1'b0, 13'd64, 13'd2, 13'd64, 12'd0, 12'd0, 1'b0, ADDR_SPACE));
      send_req(op_req(OP_START));
      hold_toggle <= ~hold_toggle;
      repeat (2 * row_bytes()) send_req(data_req(8'($urandom_range(255)) | 8'h55));
      settle();
   endtask

   task automatic test_random_images(input int n_reqs, input int idle_pct,
                                     input int stall_pct);
      int target;
      target         = reqs_sent + n_reqs;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      while (reqs_sent < target)
         random_image();
      settle();
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_PALETTE;
      csr_we     = 1'b0;
      csr_index  = CSR_FOUR_BIT_MODE;
      csr_wdata  = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      reqs_sent      = 0;
      images_started = 0;
      // shadow matches the block's reset state
      regs = make_cfg(1'b1, 13'd1, 13'd1, 13'd1, 12'd0, 12'd0, 1'b0, 25'd0);
      foreach (palette[i]) palette[i] = '0;
      byte_pos   = '0;
      row_pos    = '0;
      image_done = 1'b0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_two_bit_rows();
      test_flip_four_bit();
      test_canvas_overrun();
      test_stride_change();
      test_backpressure();
      test_random_images(45, 0, 0);
      test_random_images(45, 85, 0);
      test_random_images(45, 0, 85);
      test_random_images(45, 25, 25);
      settle();

      $display("Run: %0d requests, %0d image starts, %0d canvas writes checked.",
               reqs_sent, images_started, writes_checked);
      $display("Run: 2/4-bit, flip, overrun, stride change, size extremes, hold-off, gaps.");
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
